### sv/csem_pkg.sv
package csem_pkg;

    localparam int DEF_NUM_SEMS   = 16;
    localparam int DEF_NUM_PROCS  = 32;
    localparam int DEF_COUNT_BITS = 8;

    localparam int OP_W     = 2;
    localparam int SEL_W    = 4;
    localparam int PID_W    = 5;
    localparam int INIT_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_POST  = 2'd1;
    localparam logic [OP_W-1:0] OP_WAIT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFREE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAKE
    } state_t;

endpackage

### sv/counting_semaphore_engine.sv
// channel  direction  handshake          payload
// in       to block   in_valid/in_stall  op, sem_sel, caller_pid, initial_count
// out      from block out_valid/out_stall status, granted_sem, woke_valid, woke_pid
//
// An item goes from accept to result through one registered read of the
// semaphore record memory, then update and write back. A post that releases a
// waiter adds one registered read of the wait queue memory.
// Reset empties all queues and clears all counts at once through per-semaphore
// valid bits; the free pool comes up full. No clearing pass.
// A result waits in the output register while the next item is taken; the
// update stalls only when that register is still full at completion.
module counting_semaphore_engine import csem_pkg::*; #(
    parameter int NUM_SEMS   = DEF_NUM_SEMS,
    parameter int NUM_PROCS  = DEF_NUM_PROCS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [SEL_W-1:0]    sem_sel,
    input  logic [PID_W-1:0]    caller_pid,
    input  logic [INIT_W-1:0]   initial_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SEL_W-1:0]    granted_sem,
    output logic                woke_valid,
    output logic [PID_W-1:0]    woke_pid
);

    localparam int SEM_W  = $clog2(NUM_SEMS);
    localparam int PTR_W  = $clog2(NUM_PROCS);
    localparam int LEN_W  = $clog2(NUM_PROCS + 1);
    localparam int PLEN_W = $clog2(NUM_SEMS + 1);
    localparam int REC_W  = COUNT_BITS + 2 * PTR_W + LEN_W;
    localparam int WQ_DEPTH = NUM_SEMS << PTR_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    state_t state_reg, state_next;

    logic [OP_W-1:0]   req_op_reg;
    logic [SEL_W-1:0]  req_sel_reg;
    logic [PID_W-1:0]  req_pid_reg;
    logic [INIT_W-1:0] req_init_reg;

    logic [SEM_W-1:0]    pool_head_reg, pool_head_next;
    logic [PLEN_W-1:0]   pool_len_reg, pool_len_next;
    logic [NUM_SEMS-1:0] sem_valid_reg, sem_valid_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SEL_W-1:0]    granted_reg;
    logic                woke_valid_reg;
    logic [PID_W-1:0]    woke_pid_reg;

    logic accept, res_free, exec_go, res_load;

    logic             rec_wr_en, rec_rd_en;
    logic [SEM_W-1:0] rec_wr_addr;
    logic [REC_W-1:0] rec_wr_data, rec_rd_data, rec_cur;

    logic                   wq_wr_en, wq_rd_en;
    logic [SEM_W+PTR_W-1:0] wq_wr_addr, wq_rd_addr;
    logic [PID_W-1:0]       wq_rd_data;

    logic [SEM_W-1:0]      sel_idx;
    logic                  sel_ok, alloc_ok;
    logic [COUNT_BITS-1:0] cur_count, init_sat;
    logic [PTR_W-1:0]      cur_head, cur_tail, head_inc, tail_inc;
    logic [LEN_W-1:0]      cur_len;

    logic                  upd_write, wq_write, is_wake;
    logic [SEM_W-1:0]      upd_addr;
    logic [REC_W-1:0]      upd_rec;
    logic [STATUS_W-1:0]   res_status;
    logic [SEL_W-1:0]      res_granted;

    csem_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SEMS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_data (rec_wr_data),
        .rd_en   (rec_rd_en),
        .rd_addr (SEM_W'(sem_sel)),
        .rd_data (rec_rd_data)
    );

    csem_ram #(
        .WIDTH (PID_W),
        .DEPTH (WQ_DEPTH)
    ) u_wq_ram (
        .clk     (clk),
        .wr_en   (wq_wr_en),
        .wr_addr (wq_wr_addr),
        .wr_data (req_pid_reg),
        .rd_en   (wq_rd_en),
        .rd_addr (wq_rd_addr),
        .rd_data (wq_rd_data)
    );

    assign accept   = in_valid && !in_stall;
    assign res_free = !out_valid_reg || !out_stall;

    assign sel_idx  = SEM_W'(req_sel_reg);
    assign sel_ok   = 32'(req_sel_reg) < NUM_SEMS;
    assign alloc_ok = pool_len_reg != '0;

    assign rec_cur = sem_valid_reg[sel_idx] ? rec_rd_data : '0;
    assign {cur_count, cur_head, cur_tail, cur_len} = rec_cur;

    assign head_inc = (32'(cur_head) + 1 >= NUM_PROCS) ? '0 : cur_head + PTR_W'(1);
    assign tail_inc = (32'(cur_tail) + 1 >= NUM_PROCS) ? '0 : cur_tail + PTR_W'(1);
    assign init_sat = (32'(req_init_reg) > 32'(CNT_MAX)) ? CNT_MAX
                                                         : COUNT_BITS'(req_init_reg);

    assign wq_wr_addr = {sel_idx, cur_tail};
    assign wq_rd_addr = {sel_idx, cur_head};

    always_comb
    begin
        upd_write   = 1'b0;
        wq_write    = 1'b0;
        is_wake     = 1'b0;
        upd_addr    = sel_idx;
        upd_rec     = rec_cur;
        res_status  = STATUS_DONE;
        res_granted = '0;
        case (req_op_reg)
            OP_ALLOC:
            begin
                if (alloc_ok)
                begin
                    upd_write   = 1'b1;
                    upd_addr    = pool_head_reg;
                    upd_rec     = {init_sat, {(2 * PTR_W + LEN_W){1'b0}}};
                    res_granted = SEL_W'(pool_head_reg);
                end
                else
                begin
                    res_status = STATUS_NOFREE;
                end
            end
            OP_POST:
            begin
                if (sel_ok)
                begin
                    upd_write = 1'b1;
                    if (cur_len == '0)
                    begin
                        if (cur_count != CNT_MAX)
                        begin
                            upd_rec = {cur_count + COUNT_BITS'(1), cur_head, cur_tail, cur_len};
                        end
                    end
                    else
                    begin
                        is_wake = 1'b1;
                        upd_rec = {cur_count, head_inc, cur_tail, cur_len - LEN_W'(1)};
                    end
                end
            end
            OP_WAIT:
            begin
                if (sel_ok)
                begin
                    if (cur_count != '0)
                    begin
                        upd_write = 1'b1;
                        upd_rec   = {cur_count - COUNT_BITS'(1), cur_head, cur_tail, cur_len};
                    end
                    else if (32'(cur_len) >= NUM_PROCS)
                    begin
                        res_status = STATUS_NOFREE;
                    end
                    else
                    begin
                        upd_write  = 1'b1;
                        wq_write   = 1'b1;
                        upd_rec    = {cur_count, cur_head, tail_inc, cur_len + LEN_W'(1)};
                        res_status = STATUS_BLOCKED;
                    end
                end
            end
            default:
            begin
                upd_write = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_wake)
                begin
                    state_next = ST_WAKE;
                end
                else if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAKE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        rec_rd_en   = 1'b0;
        exec_go     = 1'b0;
        res_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                rec_rd_en = accept;
            end
            ST_EXEC:
            begin
                exec_go  = is_wake || res_free;
                res_load = !is_wake && res_free;
            end
            ST_WAKE:
            begin
                res_load = res_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        rec_wr_en   = exec_go && upd_write;
        rec_wr_addr = upd_addr;
        rec_wr_data = upd_rec;
        wq_wr_en    = exec_go && wq_write;
        wq_rd_en    = exec_go && is_wake;
    end

    always_comb
    begin
        pool_head_next = pool_head_reg;
        pool_len_next  = pool_len_reg;
        sem_valid_next = sem_valid_reg;
        if (rec_wr_en)
        begin
            sem_valid_next[rec_wr_addr] = 1'b1;
        end
        if (exec_go && req_op_reg == OP_ALLOC && alloc_ok)
        begin
            pool_head_next = (32'(pool_head_reg) + 1 >= NUM_SEMS) ? '0
                                                                  : pool_head_reg + SEM_W'(1);
            pool_len_next  = pool_len_reg - PLEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pool_head_reg <= '0;
            pool_len_reg  <= PLEN_W'(NUM_SEMS);
            sem_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_head_reg <= pool_head_next;
            pool_len_reg  <= pool_len_next;
            sem_valid_reg <= sem_valid_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg   <= op;
            req_sel_reg  <= sem_sel;
            req_pid_reg  <= caller_pid;
            req_init_reg <= initial_count;
        end
        if (res_load)
        begin
            if (state_reg == ST_WAKE)
            begin
                status_reg     <= STATUS_DONE;
                granted_reg    <= '0;
                woke_valid_reg <= 1'b1;
                woke_pid_reg   <= wq_rd_data;
            end
            else
            begin
                status_reg     <= res_status;
                granted_reg    <= res_granted;
                woke_valid_reg <= 1'b0;
                woke_pid_reg   <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign granted_sem = granted_reg;
    assign woke_valid  = woke_valid_reg;
    assign woke_pid    = woke_pid_reg;

endmodule

### sv/csem_ram.sv
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/csem_checker.sv
module csem_checker import csem_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [STATUS_W-1:0] status,
    input logic [SEL_W-1:0]    granted_sem,
    input logic                woke_valid,
    input logic [PID_W-1:0]    woke_pid
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous item in progress");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in progress");

    a_wake_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && woke_valid |-> status == STATUS_DONE && granted_sem == '0)
        else $error("wake result carries status or id");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_DONE |-> !woke_valid && granted_sem == '0
                                               && woke_pid == '0)
        else $error("failed or blocked result carries data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_sem)
                                   && $stable(woke_valid) && $stable(woke_pid))
        else $error("stalled result changed");

endmodule

bind counting_semaphore_engine csem_checker u_csem_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .granted_sem (granted_sem),
    .woke_valid  (woke_valid),
    .woke_pid    (woke_pid)
);

### dv/tb_counting_semaphore_engine.sv
import csem_pkg::*;

class semaphore_scoreboard;
    localparam int NSEMS  = DEF_NUM_SEMS;
    localparam int NPROCS = DEF_NUM_PROCS;
    localparam int CBITS  = DEF_COUNT_BITS;
    localparam longint unsigned CMAX = (64'd1 << CBITS) - 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEL_W-1:0]    granted;
        logic                woke;
        logic [PID_W-1:0]    woke_pid;
    } sem_result_t;

    longint unsigned  counts [NSEMS];
    bit [PID_W-1:0]   waiters [NSEMS][$];
    bit [SEL_W-1:0]   free_ids [$];
    sem_result_t      expected [$];
    int errors;
    int checked;
    int blocked;
    int woken;
    int refused;
    int granted_n;

    function new();
        for (int i = 0; i < NSEMS; i++)
        begin
            free_ids.push_back(SEL_W'(i));
            counts[i] = 0;
        end
    endfunction

    function int pending();
        return expected.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
                               logic [PID_W-1:0] pid, logic [INIT_W-1:0] init);
        sem_result_t r;
        bit [SEL_W-1:0] id;
        r = '0;
        case (op)
            OP_ALLOC:
            begin
                if (free_ids.size() == 0)
                begin
                    r.status = STATUS_NOFREE;
                    refused++;
                end
                else
                begin
                    id = free_ids.pop_front();
                    waiters[id].delete();
                    counts[id] = (longint'(init) > CMAX) ? CMAX : longint'(init);
                    r.granted = id;
                    granted_n++;
                end
            end
            OP_POST:
            begin
                if (int'(sel) < NSEMS)
                begin
                    if (waiters[sel].size() == 0)
                    begin
                        if (counts[sel] < CMAX)
                            counts[sel]++;
                    end
                    else
                    begin
                        r.woke = 1'b1;
                        r.woke_pid = waiters[sel].pop_front();
                        woken++;
                    end
                end
            end
            OP_WAIT:
            begin
                if (int'(sel) < NSEMS)
                begin
                    if (counts[sel] > 0)
                        counts[sel]--;
                    else if (waiters[sel].size() >= NPROCS)
                    begin
                        r.status = STATUS_NOFREE;
                        refused++;
                    end
                    else
                    begin
                        waiters[sel].push_back(pid);
                        r.status = STATUS_BLOCKED;
                        blocked++;
                    end
                end
            end
            default: ;
        endcase
        expected.push_back(r);
    endfunction

    task report(string what, int got, int want);
        errors++;
        if (errors <= 30)
            $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [SEL_W-1:0] granted,
                      logic woke, logic [PID_W-1:0] woke_pid);
        sem_result_t want;
        if (expected.size() == 0)
        begin
            report("unrequested result", int'(status), -1);
            return;
        end
        want = expected.pop_front();
        checked++;
        if (status !== want.status)
            report("status", int'(status), int'(want.status));
        if (granted !== want.granted)
            report("granted_sem", int'(granted), int'(want.granted));
        if (woke !== want.woke)
            report("woke_valid", int'(woke), int'(want.woke));
        if (woke_pid !== want.woke_pid)
            report("woke_pid", int'(woke_pid), int'(want.woke_pid));
    endtask
endclass

module tb_counting_semaphore_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 406;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op = '0;
    logic [SEL_W-1:0]    sem_sel = '0;
    logic [PID_W-1:0]    caller_pid = '0;
    logic [INIT_W-1:0]   initial_count = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SEL_W-1:0]    granted_sem;
    logic                woke_valid;
    logic [PID_W-1:0]    woke_pid;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_cycles = 0;
    int sent = 0;

    semaphore_scoreboard sb = new();

    counting_semaphore_engine dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .sem_sel(sem_sel),
        .caller_pid(caller_pid),
        .initial_count(initial_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .granted_sem(granted_sem),
        .woke_valid(woke_valid),
        .woke_pid(woke_pid)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(status, granted_sem, woke_valid, woke_pid);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] o, input logic [SEL_W-1:0] s,
                                input logic [PID_W-1:0] p, input logic [INIT_W-1:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        sem_sel <= s;
        caller_pid <= p;
        initial_count <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(o, s, p, c);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_requests(input int n_items);
        int first;
        int kind;
        int n;
        int pick;
        logic [SEL_W-1:0] s;
        first = sent;
        while (sent - first < n_items)
        begin
            kind = $urandom_range(99);
            s = SEL_W'($urandom);
            if (kind < 8)
            begin
                n = $urandom_range(34, 40);
                repeat (n)
                    send_request(OP_WAIT, s, PID_W'($urandom), INIT_W'($urandom));
            end
            else if (kind < 20)
            begin
                n = $urandom_range(1, 40);
                repeat (n)
                    send_request(OP_POST, s, PID_W'($urandom), INIT_W'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    send_request(OP_ALLOC, s, PID_W'($urandom), INIT_W'($urandom));
                else if (pick < 8)
                    send_request(OP_UNUSED, s, PID_W'($urandom), INIT_W'($urandom));
                else if (pick < 58)
                    send_request(OP_POST, s, PID_W'($urandom), INIT_W'($urandom));
                else
                    send_request(OP_WAIT, s, PID_W'($urandom), INIT_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_UNUSED, 4'd15, 5'd31, 8'd255);
        send_request(OP_POST, 4'd1, 5'd0, 8'd0);
        send_request(OP_WAIT, 4'd1, 5'd0, 8'd0);
        send_request(OP_WAIT, 4'd1, 5'd31, 8'd0);
        send_request(OP_WAIT, 4'd1, 5'd7, 8'd0);
        send_request(OP_POST, 4'd1, 5'd0, 8'd0);
        send_request(OP_ALLOC, 4'd0, 5'd0, 8'd255);
        send_request(OP_POST, 4'd0, 5'd3, 8'd0);
        send_request(OP_WAIT, 4'd0, 5'd3, 8'd0);
        send_request(OP_ALLOC, 4'd0, 5'd0, 8'd0);
        send_request(OP_POST, 4'd1, 5'd0, 8'd0);
        repeat (14)
            send_request(OP_ALLOC, SEL_W'($urandom), PID_W'($urandom),
                         INIT_W'($urandom_range(0, 3)));
        send_request(OP_ALLOC, 4'd0, 5'd0, 8'd1);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            tx_idle_pct = (phase == 1) ? 66 : (phase == 3) ? 9 : 0;
            rx_stall_pct = (phase == 2) ? 66 : (phase == 3) ? 9 : 0;
            if (phase == 0)
            begin
                random_requests(60);
                hold_cycles = 250;
                random_requests(ITEMS_PER_PHASE - 60);
            end
            else
                random_requests(ITEMS_PER_PHASE);
            drain_results();
        end

        repeat (12) @(posedge clk);
        $display("Ran %0d requests over four pacing mixes; %0d results checked.",
                 sent, sb.checked);
        $display("Ids granted %0d, callers blocked %0d, waiters released %0d, refusals %0d.",
                 sb.granted_n, sb.blocked, sb.woken, sb.refused);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
